@@ src/nmea_gga_sentence_parser_macros.svh @@
// Assertion helpers for the GGA parser.
`ifndef NMEA_GGA_SENTENCE_PARSER_MACROS_SVH
`define NMEA_GGA_SENTENCE_PARSER_MACROS_SVH

// Property checked on every clock edge outside reset.
`define NGP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked also during reset.
`define NGP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/nmea_gga_pkg.sv @@
// ----------------------------------------------------------------------------
// nmea_gga_pkg
// Constants and helpers shared by the GGA sentence parser.
// ----------------------------------------------------------------------------
package nmea_gga_pkg;

  localparam int unsigned ACC_W = 30;
  localparam int unsigned VAL_W = 44;

  localparam logic [ACC_W-1:0] ACC_CAP = ACC_W'(1000000000);

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_W     = 8'h57;

  localparam logic [3:0] FLD_TIME = 4'd0;
  localparam logic [3:0] FLD_LAT  = 4'd1;
  localparam logic [3:0] FLD_NS   = 4'd2;
  localparam logic [3:0] FLD_LON  = 4'd3;
  localparam logic [3:0] FLD_EW   = 4'd4;
  localparam logic [3:0] FLD_FIX  = 4'd5;
  localparam logic [3:0] FLD_SATS = 4'd6;
  localparam logic [3:0] FLD_HDOP = 4'd7;
  localparam logic [3:0] FLD_ALT  = 4'd8;

  localparam int unsigned TDATA_W = 136;

  // packed with utc_time in the lowest bits
  typedef struct packed {
    logic signed [20:0] altitude;
    logic [13:0] hdop;
    logic [6:0]  satellites;
    logic [3:0]  fix_quality;
    logic        lon_west;
    logic [27:0] longitude;
    logic        lat_south;
    logic [26:0] latitude;
    logic [27:0] utc_time;
  } fix_t;

  localparam fix_t FIX_RESET = '{utc_time: '0, latitude: '0, lat_south: 1'b0,
                                 longitude: '0, lon_west: 1'b1, fix_quality: '0,
                                 satellites: '0, hdop: '0, altitude: '0};

  function automatic logic [7:0] header_char(input logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    unique case (pos)
      3'd0: ch = 8'h24;
      3'd1: ch = 8'h47;
      3'd2: ch = 8'h50;
      3'd3: ch = 8'h47;
      3'd4: ch = 8'h47;
      3'd5: ch = 8'h41;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] scale_digits(input logic [3:0] fld);
    logic [2:0] d;
    d = 3'd0;
    unique case (fld)
      FLD_TIME: d = 3'd3;
      FLD_LAT:  d = 3'd4;
      FLD_LON:  d = 3'd4;
      FLD_HDOP: d = 3'd2;
      FLD_ALT:  d = 3'd1;
      default:  d = 3'd0;
    endcase
    return d;
  endfunction

  function automatic logic [13:0] pow10(input logic [2:0] e);
    logic [13:0] p;
    p = 14'd1;
    unique case (e)
      3'd1: p = 14'd10;
      3'd2: p = 14'd100;
      3'd3: p = 14'd1000;
      3'd4: p = 14'd10000;
      default: p = 14'd1;
    endcase
    return p;
  endfunction

  function automatic logic [31:0] clamp_u(input logic [VAL_W-1:0] v, input logic minus,
                                          input logic [31:0] maxv);
    logic [31:0] r;
    if (minus) r = '0;
    else if (v > VAL_W'(maxv)) r = maxv;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] h;
    if (c >= 8'h30 && c <= 8'h39) h = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) h = {1'b0, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) h = {1'b0, 4'(c - 8'h57)};
    else h = 5'h10;
    return h;
  endfunction

endpackage

@@ src/nmea_gga_sentence_parser.sv @@
// ----------------------------------------------------------------------------
// nmea_gga_sentence_parser
// Parses $GPGGA lines from a received byte stream into fixed-point fields.
// ----------------------------------------------------------------------------
// Slave stream s_*: one received character per item (s_tdata[7:0]).
// Master stream m_*: one item per $GPGGA line, sent when its newline arrives.
// It carries the held fix (updated when the line's checksum matched),
// a flag telling whether this line was taken, and a flag set once any line
// has been taken since reset. Other lines produce nothing.
// Every accepted character updates the parse state in the same cycle; the
// result of a newline is in the output register in the next cycle.
// Throughput is one character per cycle, limited only by the single output
// register: s_tready drops only while a result waits and m_tready is low,
// and it stays high in a cycle where the waiting result is taken.
// Reset (rst, synchronous) clears the line state, the pending and held fix
// (west flag set, all else zero), data_valid and m_tvalid; m_tdata is not reset.
// A stalled result holds its value until taken.
// ----------------------------------------------------------------------------
module nmea_gga_sentence_parser (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // rx_byte[7:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  // utc_time[27:0], latitude[54:28], lat_south[55], longitude[83:56],
  // lon_west[84], fix_quality[88:85], satellites[95:89], hdop[109:96],
  // altitude[130:110], sentence_accepted[131], data_valid[132], zero[135:133]
  output logic [nmea_gga_pkg::TDATA_W-1:0] m_tdata
);
  import nmea_gga_pkg::*;

  logic [2:0]       header_position, header_position_next;
  logic             header_mismatch, header_mismatch_next;
  logic [3:0]       field_number, field_number_next;
  logic             first_comma_seen, first_comma_seen_next;
  logic             in_checksum_part, in_checksum_part_next;
  logic [7:0]       xor_acc, xor_acc_next;
  logic [7:0]       received_sum, received_sum_next;
  logic [1:0]       hex_count, hex_count_next;
  logic [ACC_W-1:0] num_acc, num_acc_next;
  logic [2:0]       frac_count, frac_count_next;
  logic             flag_point, flag_point_next;
  logic             flag_minus, flag_minus_next;
  logic             flag_stop, flag_stop_next;
  fix_t             pending, pending_next;
  fix_t             held, held_next;
  logic             valid_seen, valid_seen_next;
  logic             out_load;
  logic             out_ok;

  logic             in_acc;
  logic [7:0]       c;
  logic [2:0]       want;
  logic [VAL_W-1:0] scaled;
  logic [33:0]      digit_sum;
  logic [4:0]       hv;
  logic [16:0]      alt_mag;

  assign in_acc   = s_tvalid && s_tready;
  assign s_tready = !m_tvalid || m_tready;
  assign c        = s_tdata;
  assign want     = scale_digits(field_number);
  assign scaled   = VAL_W'(num_acc) *
                    VAL_W'(pow10((frac_count < want) ? 3'(want - frac_count) : 3'd0));
  assign digit_sum = 34'(num_acc) * 34'd10 + 34'(c[3:0]);
  assign hv       = hex_value(c);

  always_comb begin
    header_position_next  = header_position;
    header_mismatch_next  = header_mismatch;
    field_number_next     = field_number;
    first_comma_seen_next = first_comma_seen;
    in_checksum_part_next = in_checksum_part;
    xor_acc_next          = xor_acc;
    received_sum_next     = received_sum;
    hex_count_next        = hex_count;
    num_acc_next          = num_acc;
    frac_count_next       = frac_count;
    flag_point_next       = flag_point;
    flag_minus_next       = flag_minus;
    flag_stop_next        = flag_stop;
    pending_next          = pending;
    held_next             = held;
    valid_seen_next       = valid_seen;
    out_load              = 1'b0;
    out_ok                = 1'b0;
    alt_mag               = '0;

    if (in_acc) begin
      if (c == CH_NL) begin
        if (header_position == 3'd6 && !header_mismatch) begin
          out_load = 1'b1;
          out_ok   = in_checksum_part && hex_count == 2'd2 && received_sum == xor_acc;
          if (out_ok) begin
            held_next       = pending;
            valid_seen_next = 1'b1;
          end
        end
        header_position_next  = '0;
        header_mismatch_next  = 1'b0;
        field_number_next     = '0;
        first_comma_seen_next = 1'b0;
        in_checksum_part_next = 1'b0;
        xor_acc_next          = '0;
        received_sum_next     = '0;
        hex_count_next        = '0;
        num_acc_next          = '0;
        frac_count_next       = '0;
        flag_point_next       = 1'b0;
        flag_minus_next       = 1'b0;
        flag_stop_next        = 1'b0;
        pending_next          = FIX_RESET;
      end else begin
        if (header_position < 3'd6) begin
          if (c != header_char(header_position)) header_mismatch_next = 1'b1;
          header_position_next = header_position + 3'd1;
        end
        if (header_position != 3'd0) begin
          if (in_checksum_part) begin
            if (hex_count < 2'd2) begin
              if (hv[4]) hex_count_next = 2'd3;
              else begin
                received_sum_next = {received_sum[3:0], hv[3:0]};
                hex_count_next    = hex_count + 2'd1;
              end
            end
          end else begin
            if (c != CH_STAR) xor_acc_next = xor_acc ^ c;
            if (c == CH_COMMA || c == CH_STAR) begin
              if (!first_comma_seen) first_comma_seen_next = 1'b1;
              else begin
                case (field_number)
                  FLD_TIME: pending_next.utc_time =
                    28'(clamp_u(scaled, flag_minus, 32'd235959999));
                  FLD_LAT: pending_next.latitude =
                    27'(clamp_u(scaled, flag_minus, 32'd90000000));
                  FLD_LON: pending_next.longitude =
                    28'(clamp_u(scaled, flag_minus, 32'd180000000));
                  FLD_FIX: pending_next.fix_quality =
                    4'(clamp_u(scaled, flag_minus, 32'd9));
                  FLD_SATS: pending_next.satellites =
                    7'(clamp_u(scaled, flag_minus, 32'd99));
                  FLD_HDOP: pending_next.hdop =
                    14'(clamp_u(scaled, flag_minus, 32'd9999));
                  FLD_ALT: begin
                    if (flag_minus) begin
                      alt_mag = (scaled > VAL_W'(99999)) ? 17'd99999 : scaled[16:0];
                      pending_next.altitude = -$signed({4'd0, alt_mag});
                    end else begin
                      pending_next.altitude =
                        21'(clamp_u(scaled, 1'b0, 32'd999999));
                    end
                  end
                  default: ;
                endcase
                if (field_number != 4'd15) field_number_next = field_number + 4'd1;
              end
              num_acc_next    = '0;
              frac_count_next = '0;
              flag_point_next = 1'b0;
              flag_minus_next = 1'b0;
              flag_stop_next  = 1'b0;
              if (c == CH_STAR) in_checksum_part_next = 1'b1;
            end else if (first_comma_seen) begin
              if (field_number == FLD_NS) begin
                if (c == CH_S) pending_next.lat_south = 1'b1;
                else if (c == CH_N) pending_next.lat_south = 1'b0;
              end else if (field_number == FLD_EW) begin
                if (c == CH_W) pending_next.lon_west = 1'b1;
                else if (c == CH_E) pending_next.lon_west = 1'b0;
              end else if (!flag_stop) begin
                if (c >= 8'h30 && c <= 8'h39) begin
                  if (!flag_point || frac_count < want) begin
                    if (flag_point) frac_count_next = frac_count + 3'd1;
                    num_acc_next = (digit_sum > 34'(ACC_CAP)) ? ACC_CAP
                                                              : digit_sum[ACC_W-1:0];
                  end
                end else if (c == CH_POINT) begin
                  if (flag_point) flag_stop_next = 1'b1;
                  else flag_point_next = 1'b1;
                end else if ((c == CH_MINUS || c == CH_PLUS) && num_acc == '0 &&
                             !flag_point && !flag_minus) begin
                  if (c == CH_MINUS) flag_minus_next = 1'b1;
                end else begin
                  flag_stop_next = 1'b1;
                end
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_position  <= '0;
      header_mismatch  <= 1'b0;
      field_number     <= '0;
      first_comma_seen <= 1'b0;
      in_checksum_part <= 1'b0;
      xor_acc          <= '0;
      received_sum     <= '0;
      hex_count        <= '0;
      num_acc          <= '0;
      frac_count       <= '0;
      flag_point       <= 1'b0;
      flag_minus       <= 1'b0;
      flag_stop        <= 1'b0;
      pending          <= FIX_RESET;
      held             <= FIX_RESET;
      valid_seen       <= 1'b0;
      m_tvalid         <= 1'b0;
    end else begin
      header_position  <= header_position_next;
      header_mismatch  <= header_mismatch_next;
      field_number     <= field_number_next;
      first_comma_seen <= first_comma_seen_next;
      in_checksum_part <= in_checksum_part_next;
      xor_acc          <= xor_acc_next;
      received_sum     <= received_sum_next;
      hex_count        <= hex_count_next;
      num_acc          <= num_acc_next;
      frac_count       <= frac_count_next;
      flag_point       <= flag_point_next;
      flag_minus       <= flag_minus_next;
      flag_stop        <= flag_stop_next;
      pending          <= pending_next;
      held             <= held_next;
      valid_seen       <= valid_seen_next;
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {3'b000, valid_seen_next, out_ok, held_next.altitude,
                  held_next.hdop, held_next.satellites, held_next.fix_quality,
                  held_next.lon_west, held_next.longitude, held_next.lat_south,
                  held_next.latitude, held_next.utc_time};
    end
  end

`include "nmea_gga_sentence_parser_macros.svh"

  `NGP_ASSERT(a_stall_only_when_full, !s_tready |-> (m_tvalid && !m_tready), "bad stall")
  `NGP_ASSERT(a_result_from_newline, $rose(m_tvalid) |-> $past(in_acc && c == CH_NL), "stray result")
  `NGP_ASSERT(a_accept_implies_valid, m_tvalid && m_tdata[131] |-> m_tdata[132] && valid_seen, "valid flag")
  `NGP_ASSERT(a_newline_clears_line, in_acc && c == CH_NL |=> header_position == 3'd0 && !in_checksum_part, "line reset")
  `NGP_ASSERT(a_reset_empty, $past(rst) |-> !m_tvalid, "output after reset")

endmodule
